>>> rtl/core/spq_pkg.sv
package spq_pkg;

  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT   = 3'd0,
    ACT_DEL_PRIO = 3'd1,
    ACT_DEL_TAG  = 3'd2,
    ACT_SEARCH   = 3'd3,
    ACT_POP      = 3'd4,
    ACT_CLEAR    = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  // What every cell of the chain does in a given cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_CLEAR,
    CELL_SCAN_CLR,
    CELL_SCAN_STEP,
    CELL_REMOVE
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } slot_t;

  typedef struct packed {
    cell_op_e          op;
    logic              by_tag;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } cell_ctl_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    out_tag;
    logic [PRIO_W-1:0]   out_prio;
    logic [COUNT_W-1:0]  entry_count;
  } res_t;

endpackage

>>> rtl/core/spq_cell.sv
// One slot of the sorted chain. It holds an entry, trades it with its
// neighbors on insert, pop and remove, and carries the two scan chains.
module spq_cell import spq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  slot_t     left_slot_i,
  input  slot_t     right_slot_i,
  input  logic      left_lt_i,
  input  logic      left_seen_i,
  input  slot_t     right_fwd_i,
  output slot_t     slot_o,
  output logic      lt_o,
  output logic      seen_o,
  output slot_t     fwd_o
);

  logic              valid_q, valid_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic              seen_q, seen_d;
  logic              fwd_valid_q;
  logic [PRIO_W-1:0] fwd_prio_q;
  logic [TAG_W-1:0]  fwd_tag_q;
  slot_t             fwd_d;
  logic              lt;
  logic              hit;

  assign lt  = valid_q && (prio_q < ctl_i.prio);
  assign hit = valid_q && (ctl_i.by_tag ? (tag_q == ctl_i.tag) : (prio_q == ctl_i.prio));

  always_comb begin
    valid_d = valid_q;
    prio_d  = prio_q;
    tag_d   = tag_q;
    seen_d  = seen_q;
    fwd_d   = fwd_o;
    case (ctl_i.op)
      CELL_INSERT: begin
        if (!lt) begin
          if (left_lt_i) begin
            valid_d = 1'b1;
            prio_d  = ctl_i.prio;
            tag_d   = ctl_i.tag;
          end else begin
            valid_d = left_slot_i.valid;
            prio_d  = left_slot_i.prio;
            tag_d   = left_slot_i.tag;
          end
        end
      end
      CELL_POP: begin
        valid_d = right_slot_i.valid;
        prio_d  = right_slot_i.prio;
        tag_d   = right_slot_i.tag;
      end
      CELL_CLEAR: begin
        valid_d = 1'b0;
      end
      CELL_SCAN_CLR: begin
        seen_d       = 1'b0;
        fwd_d.valid  = 1'b0;
      end
      CELL_SCAN_STEP: begin
        seen_d = hit || left_seen_i;
        if (hit) begin
          fwd_d.valid = 1'b1;
          fwd_d.prio  = prio_q;
          fwd_d.tag   = tag_q;
        end else begin
          fwd_d = right_fwd_i;
        end
      end
      CELL_REMOVE: begin
        if (seen_q) begin
          valid_d = right_slot_i.valid;
          prio_d  = right_slot_i.prio;
          tag_d   = right_slot_i.tag;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      seen_q      <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      seen_q      <= seen_d;
      fwd_valid_q <= fwd_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q     <= prio_d;
    tag_q      <= tag_d;
    fwd_prio_q <= fwd_d.prio;
    fwd_tag_q  <= fwd_d.tag;
  end

  assign slot_o = '{valid: valid_q, prio: prio_q, tag: tag_q};
  assign lt_o   = lt;
  assign seen_o = seen_q;
  assign fwd_o  = '{valid: fwd_valid_q, prio: fwd_prio_q, tag: fwd_tag_q};

endmodule

>>> rtl/core/sorted_priority_queue.sv
// Sorted priority queue of DEPTH entries kept in ascending priority order in a
// row of cells, each cell holding one entry. An item is accepted at a rising
// edge where start_i is high and busy_o is low, and gives exactly one result,
// shown on res_o for one cycle while done_o is high; the receiver cannot stall,
// so every result must be taken in the cycle it appears. Insert, pop head,
// clear and the unused action codes need no scan: busy_o stays low, a new
// item can be accepted in the very next cycle, and the registered result
// appears in the cycle after acceptance. Delete by priority, delete by tag
// and search keep busy_o high through a scan and a commit step; the first
// matching entry is found by two chains that move one cell per cycle across
// the row (one marks every cell at or after the match, the other carries
// the matching entry toward the head), so the row's length sets the scan's.
// An insert into a full queue is dropped with status full. The entry count
// on the result is the count after the item, taken modulo 32.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  cmd_t cmd_i,
  output logic busy_o,
  output logic done_o,
  output res_t res_o
);

  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SCAN_W = $clog2(DEPTH);

  state_e            state_q, state_d;
  logic [SCAN_W-1:0] scan_q, scan_d;
  logic [CNT_W-1:0]  count_q, count_d;
  cmd_t              op_q, op_d;
  logic              done_q, done_d;
  res_t              res_q, res_d;
  cell_ctl_t         ctl;
  logic              accept;
  logic              full;
  logic              empty;

  // Per-cell views of the chain.
  slot_t slot_w [DEPTH];
  slot_t fwd_w  [DEPTH];
  logic  lt_w   [DEPTH];
  logic  seen_w [DEPTH];

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    slot_t left_slot, right_slot, right_fwd;
    logic  left_lt, left_seen;

    if (i == 0) begin : g_head
      assign left_slot = '0;
      assign left_lt   = 1'b1;
      assign left_seen = 1'b0;
    end else begin : g_mid_l
      assign left_slot = slot_w[i-1];
      assign left_lt   = lt_w[i-1];
      assign left_seen = seen_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_slot = '0;
      assign right_fwd  = '0;
    end else begin : g_mid_r
      assign right_slot = slot_w[i+1];
      assign right_fwd  = fwd_w[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .left_slot_i  (left_slot),
      .right_slot_i (right_slot),
      .left_lt_i    (left_lt),
      .left_seen_i  (left_seen),
      .right_fwd_i  (right_fwd),
      .slot_o       (slot_w[i]),
      .lt_o         (lt_w[i]),
      .seen_o       (seen_w[i]),
      .fwd_o        (fwd_w[i])
    );
  end

  // Sequencer: operations without a scan are decoded straight off the command,
  // while lookups go through a scan of DEPTH steps and a final commit step.
  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    count_d    = count_q;
    op_d       = op_q;
    done_d     = 1'b0;
    res_d      = '0;
    ctl.op     = CELL_HOLD;
    ctl.by_tag = (op_q.action == ACT_DEL_TAG);
    ctl.prio   = op_q.prio;
    ctl.tag    = op_q.tag;

    unique case (state_q)
      S_IDLE: begin
        ctl.prio = cmd_i.prio;
        ctl.tag  = cmd_i.tag;
        if (accept) begin
          done_d = 1'b1;
          unique case (cmd_i.action) inside
            ACT_INSERT: begin
              if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                ctl.op  = CELL_INSERT;
                count_d = count_q + 1'b1;
              end
            end
            ACT_DEL_PRIO, ACT_DEL_TAG, ACT_SEARCH: begin
              // The result waits for the end of the scan.
              done_d  = 1'b0;
              ctl.op  = CELL_SCAN_CLR;
              op_d    = cmd_i;
              scan_d  = '0;
              state_d = S_SCAN;
            end
            ACT_POP: begin
              if (empty) begin
                res_d.status = STAT_NOT_FOUND;
              end else begin
                ctl.op         = CELL_POP;
                res_d.out_tag  = slot_w[0].tag;
                res_d.out_prio = slot_w[0].prio;
                count_d        = count_q - 1'b1;
              end
            end
            ACT_CLEAR: begin
              ctl.op  = CELL_CLEAR;
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        ctl.op = CELL_SCAN_STEP;
        scan_d = scan_q + 1'b1;
        if (scan_q == SCAN_W'(DEPTH - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // The head cell's forward chain now holds the first match, if any.
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (!fwd_w[0].valid) begin
          res_d.status = STAT_NOT_FOUND;
        end else if (op_q.action == ACT_SEARCH) begin
          res_d.out_tag  = fwd_w[0].tag;
          res_d.out_prio = fwd_w[0].prio;
        end else begin
          ctl.op  = CELL_REMOVE;
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.entry_count = COUNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scan_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> rtl/core/spq_checker.sv
module spq_checker import spq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input res_t res_o
);

  // An accepted item either answers in the next cycle or starts a scan.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> done_o || busy_o)
    else $error("accepted item neither answered nor started a scan");

  // The end of a scan always delivers its result.
  a_scan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("scan ended without a result");

  // A dropped insert is reported only when the queue is full.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.status == STAT_FULL) |-> res_o.entry_count == COUNT_W'(DEPTH))
    else $error("full status with a queue that is not full");

  // A failed item reports no entry.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.status != STAT_OK) |-> res_o.out_tag == '0 && res_o.out_prio == '0)
    else $error("failed item reports entry data");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);
